/* rtl/core/yb2b_pkg.sv */
// Package for the 4:2:0 block to BGR converter: field structs, widths and
// fixed-point BT.601 coefficients. Depends on nothing; used by every module.
`timescale 1ns / 1ps

package yb2b_pkg;

	// Width of one color or sample byte.
	localparam int BYTE_W = 8;
	// Width of a signed chroma offset (U - 128 or V - 128).
	localparam int CHROMA_W = BYTE_W + 1;
	// Width of a signed chroma product term.
	localparam int TERM_W = 26;
	// Width of a signed per-component sum.
	localparam int SUM_W = 27;

	// Pipeline depth from an accepted transfer to its result strobe.
	localparam int LATENCY = 4;

	// Coefficients in 16 fractional bits.
	localparam logic signed [SUM_W-1:0]  COEF_LUMA = 27'sd76310;
	localparam logic signed [TERM_W-1:0] COEF_B_U  = 26'sd132278;
	localparam logic signed [TERM_W-1:0] COEF_G_U  = 26'sd25690;
	localparam logic signed [TERM_W-1:0] COEF_G_V  = 26'sd53294;
	localparam logic signed [TERM_W-1:0] COEF_R_V  = 26'sd104635;

	localparam logic signed [CHROMA_W-1:0] CHROMA_BIAS = 9'sd128;
	localparam logic [BYTE_W-1:0]          LUMA_BIAS   = 8'd16;

	// Clamp limits: at or below LOW_LIMIT gives zero, above HIGH_LIMIT gives full scale.
	localparam logic signed [SUM_W-1:0] LOW_LIMIT  = 27'sh000FFFF;
	localparam logic signed [SUM_W-1:0] HIGH_LIMIT = 27'sh0FFFFFF;
	localparam logic [BYTE_W-1:0]       FULL_SCALE = 8'hFF;

	// One input transfer: a 2x2 luma block with its shared chroma pair.
	typedef struct packed {
		logic [BYTE_W-1:0] luma_top_left;
		logic [BYTE_W-1:0] luma_top_right;
		logic [BYTE_W-1:0] luma_bottom_left;
		logic [BYTE_W-1:0] luma_bottom_right;
		logic [BYTE_W-1:0] chroma_u;
		logic [BYTE_W-1:0] chroma_v;
	} samples_t;

	// One result transfer: four pixels in blue, green, red order.
	typedef struct packed {
		logic [BYTE_W-1:0] blue_top_left;
		logic [BYTE_W-1:0] green_top_left;
		logic [BYTE_W-1:0] red_top_left;
		logic [BYTE_W-1:0] blue_top_right;
		logic [BYTE_W-1:0] green_top_right;
		logic [BYTE_W-1:0] red_top_right;
		logic [BYTE_W-1:0] blue_bottom_left;
		logic [BYTE_W-1:0] green_bottom_left;
		logic [BYTE_W-1:0] red_bottom_left;
		logic [BYTE_W-1:0] blue_bottom_right;
		logic [BYTE_W-1:0] green_bottom_right;
		logic [BYTE_W-1:0] red_bottom_right;
	} pixels_t;

	// One pixel out of a luma lane.
	typedef struct packed {
		logic [BYTE_W-1:0] blue;
		logic [BYTE_W-1:0] green;
		logic [BYTE_W-1:0] red;
	} bgr_t;

	// Shared chroma product terms handed from the chroma unit to the lanes.
	typedef struct packed {
		logic signed [TERM_W-1:0] b_u;
		logic signed [TERM_W-1:0] g_u;
		logic signed [TERM_W-1:0] g_v;
		logic signed [TERM_W-1:0] r_v;
	} chroma_terms_t;

endpackage

/* rtl/core/yuv420_block_to_bgr.sv */
// Top level of the 4:2:0 block to BGR converter: valid pipeline, one shared
// chroma unit and four luma lanes. Depends on yb2b_pkg, yb2b_chroma, yb2b_lane.
`timescale 1ns / 1ps

// A 2x2 block of 4:2:0 samples is taken on any cycle with start high; busy
// is always low, so one block can enter every clock. The four BGR pixels
// appear on pixels with done high for exactly one cycle, after the four
// register stages of the luma lanes (bias removal, coefficient multiply,
// chroma add, saturation). The receiver cannot stall, so results must be
// captured in the cycle done is high.
module yuv420_block_to_bgr (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  yb2b_pkg::samples_t samples,
	output logic               done,
	output yb2b_pkg::pixels_t  pixels
);

	logic                    valid_s1;
	logic                    valid_s2;
	logic                    valid_s3;
	logic                    valid_s4;
	yb2b_pkg::chroma_terms_t terms;
	yb2b_pkg::bgr_t          pixel_tl;
	yb2b_pkg::bgr_t          pixel_tr;
	yb2b_pkg::bgr_t          pixel_bl;
	yb2b_pkg::bgr_t          pixel_br;

	// The pipeline never stalls, so a transfer is always taken.
	assign busy = 1'b0;

	// Valid bits follow each block down the four stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	assign done = valid_s4;

	// Chroma terms shared by all four pixels.
	yb2b_chroma u_chroma (
		.clk      (clk),
		.chroma_u (samples.chroma_u),
		.chroma_v (samples.chroma_v),
		.terms    (terms)
	);

	// One lane per pixel of the block.
	yb2b_lane u_lane_tl (
		.clk   (clk),
		.luma  (samples.luma_top_left),
		.terms (terms),
		.pixel (pixel_tl)
	);

	yb2b_lane u_lane_tr (
		.clk   (clk),
		.luma  (samples.luma_top_right),
		.terms (terms),
		.pixel (pixel_tr)
	);

	yb2b_lane u_lane_bl (
		.clk   (clk),
		.luma  (samples.luma_bottom_left),
		.terms (terms),
		.pixel (pixel_bl)
	);

	yb2b_lane u_lane_br (
		.clk   (clk),
		.luma  (samples.luma_bottom_right),
		.terms (terms),
		.pixel (pixel_br)
	);

	// Gather the lanes into the result struct.
	always_comb begin
		pixels.blue_top_left      = pixel_tl.blue;
		pixels.green_top_left     = pixel_tl.green;
		pixels.red_top_left       = pixel_tl.red;
		pixels.blue_top_right     = pixel_tr.blue;
		pixels.green_top_right    = pixel_tr.green;
		pixels.red_top_right      = pixel_tr.red;
		pixels.blue_bottom_left   = pixel_bl.blue;
		pixels.green_bottom_left  = pixel_bl.green;
		pixels.red_bottom_left    = pixel_bl.red;
		pixels.blue_bottom_right  = pixel_br.blue;
		pixels.green_bottom_right = pixel_br.green;
		pixels.red_bottom_right   = pixel_br.red;
	end

endmodule

/* rtl/core/yb2b_chroma.sv */
// Shared chroma unit: removes the chroma bias and forms the four chroma
// product terms over two register stages. Depends on yb2b_pkg.
`timescale 1ns / 1ps

module yb2b_chroma (
	input  logic                          clk,
	input  logic [yb2b_pkg::BYTE_W-1:0]   chroma_u,
	input  logic [yb2b_pkg::BYTE_W-1:0]   chroma_v,
	output yb2b_pkg::chroma_terms_t       terms
);

	logic signed [yb2b_pkg::CHROMA_W-1:0] u_s1;
	logic signed [yb2b_pkg::CHROMA_W-1:0] v_s1;
	yb2b_pkg::chroma_terms_t              terms_s2;

	// Stage 1: signed offsets around the chroma midpoint.
	always_ff @(posedge clk) begin
		u_s1 <= $signed({1'b0, chroma_u}) - yb2b_pkg::CHROMA_BIAS;
		v_s1 <= $signed({1'b0, chroma_v}) - yb2b_pkg::CHROMA_BIAS;
	end

	// Stage 2: one constant multiply per term, registered.
	always_ff @(posedge clk) begin
		terms_s2.b_u <= yb2b_pkg::TERM_W'(u_s1) * yb2b_pkg::COEF_B_U;
		terms_s2.g_u <= yb2b_pkg::TERM_W'(u_s1) * yb2b_pkg::COEF_G_U;
		terms_s2.g_v <= yb2b_pkg::TERM_W'(v_s1) * yb2b_pkg::COEF_G_V;
		terms_s2.r_v <= yb2b_pkg::TERM_W'(v_s1) * yb2b_pkg::COEF_R_V;
	end

	assign terms = terms_s2;

endmodule

/* rtl/core/yb2b_lane.sv */
// One luma lane: clips and scales a luma sample, adds the shared chroma
// terms and clamps each sum to a byte. Depends on yb2b_pkg.
`timescale 1ns / 1ps

module yb2b_lane (
	input  logic                          clk,
	input  logic [yb2b_pkg::BYTE_W-1:0]   luma,
	input  yb2b_pkg::chroma_terms_t       terms,
	output yb2b_pkg::bgr_t                pixel
);

	logic [yb2b_pkg::BYTE_W-1:0]       y_s1;
	logic signed [yb2b_pkg::SUM_W-1:0] l_s2;
	logic signed [yb2b_pkg::SUM_W-1:0] blue_s3;
	logic signed [yb2b_pkg::SUM_W-1:0] green_s3;
	logic signed [yb2b_pkg::SUM_W-1:0] red_s3;
	yb2b_pkg::bgr_t                    pixel_s4;

	// Clamp a sum to a byte: non-positive and small sums give zero.
	function automatic logic [yb2b_pkg::BYTE_W-1:0] clamp_byte(
		input logic signed [yb2b_pkg::SUM_W-1:0] s
	);
		logic [yb2b_pkg::BYTE_W-1:0] r;
		if (s > yb2b_pkg::HIGH_LIMIT) begin
			r = yb2b_pkg::FULL_SCALE;
		end else if (s <= yb2b_pkg::LOW_LIMIT) begin
			r = '0;
		end else begin
			r = s[23:16];
		end
		return r;
	endfunction

	// Stage 1: the luma bias is removed and footroom is clipped to zero.
	always_ff @(posedge clk) begin
		y_s1 <= (luma >= yb2b_pkg::LUMA_BIAS) ? luma - yb2b_pkg::LUMA_BIAS : '0;
	end

	// Stage 2: scale the luma by its coefficient.
	always_ff @(posedge clk) begin
		l_s2 <= $signed(yb2b_pkg::SUM_W'(y_s1)) * yb2b_pkg::COEF_LUMA;
	end

	// Stage 3: add the chroma terms that arrive aligned with this stage.
	always_ff @(posedge clk) begin
		blue_s3  <= l_s2 + yb2b_pkg::SUM_W'(terms.b_u);
		green_s3 <= l_s2 - yb2b_pkg::SUM_W'(terms.g_u) - yb2b_pkg::SUM_W'(terms.g_v);
		red_s3   <= l_s2 + yb2b_pkg::SUM_W'(terms.r_v);
	end

	// Stage 4: saturate into the output register.
	always_ff @(posedge clk) begin
		pixel_s4.blue  <= clamp_byte(blue_s3);
		pixel_s4.green <= clamp_byte(green_s3);
		pixel_s4.red   <= clamp_byte(red_s3);
	end

	assign pixel = pixel_s4;

endmodule

/* rtl/core/yb2b_checker.sv */
// Port-level checker for the 4:2:0 block to BGR converter, with its bind.
// Depends on yb2b_pkg and the ports of yuv420_block_to_bgr.
`timescale 1ns / 1ps

module yb2b_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input yb2b_pkg::samples_t samples,
	input logic               done,
	input yb2b_pkg::pixels_t  pixels
);

	// The converter always takes a transfer.
	assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	// Every accepted block yields a result after the fixed latency.
	assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##4 done)
		else $error("result missing after accepted block");

	// No result without a block accepted at the fixed latency before it.
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 4))
		else $error("result without a matching accepted block");

	// Black input with neutral chroma gives an all-zero result.
	assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && samples.chroma_u == 8'd128 && samples.chroma_v == 8'd128
		&& samples.luma_top_left <= 8'd16 && samples.luma_top_right <= 8'd16
		&& samples.luma_bottom_left <= 8'd16 && samples.luma_bottom_right <= 8'd16
		|-> ##4 (pixels == '0))
		else $error("black block did not give zero pixels");

endmodule

bind yuv420_block_to_bgr yb2b_checker u_yb2b_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.busy    (busy),
	.samples (samples),
	.done    (done),
	.pixels  (pixels)
);
